// ===== src/cumulative_log_sum_exp_scan_macros.svh =====
// assertion helpers for the cumulative log-sum-exp scan
`ifndef CUMULATIVE_LOG_SUM_EXP_SCAN_MACROS_SVH
`define CUMULATIVE_LOG_SUM_EXP_SCAN_MACROS_SVH
`ifndef SYNTHESIS
`define CLSE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clse assertion failed");
`define CLSE_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("clse assertion failed");
`else
`define CLSE_ASSERT(name, prop)
`define CLSE_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== src/clse_pkg.sv =====
package clse_pkg;

  localparam int VALUE_FRAC_BITS = 16;
  localparam int SUM_INT_BITS    = 16;
  localparam int SUM_FRAC_BITS   = 24;

  localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
  localparam logic [32:0] LN2_Q28   = 33'd186065280;

  typedef logic [32:0][32:0] pow_tab_t;

  typedef enum logic [2:0] {
    MUL_LOG2E,
    MUL_POW,
    MUL_SUM_LO,
    MUL_SUM_HI,
    MUL_SQUARE,
    MUL_LN2
  } mul_op_e;

  typedef struct packed {
    logic [32:0] dlt;
    logic [32:0] p;
    logic [32:0] tab;
    logic [32:0] sum_lo;
    logic [32:0] sum_hi;
    logic [32:0] e;
    logic [32:0] m;
    logic [32:0] l2;
  } mul_opd_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-2^-k) in q32 for k >= 1 (entry 0 holds one), chained square roots from one half
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] prev;
    prev   = 64'd1 << 31;
    tab[0] = 33'd1 << 32;
    for (int k = 1; k <= 32; k++) begin
      tab[k] = 33'(isqrt64(prev << 32));
      prev   = 64'(tab[k]);
    end
    return tab;
  endfunction

endpackage

// ===== src/cumulative_log_sum_exp_scan.sv =====
// Cumulative log-sum-exp over rows of signed fixed-point samples. One word in gives one word
// out; in_ready_o stays low while a word is worked on. Every multiplication runs through one
// shared 33x33 multiplier under a sequencer. The exp runs the log2(e) scaling, 32 product
// steps and the final shift. The log runs set-up, a normalising search of clog2(sum width)
// steps, 28 squaring steps and the ln2 scaling. Each word also passes the idle accept,
// dispatch, update and emit states. A smaller or equal sample then accumulates; a new maximum
// takes a rescale of two steps instead. When the difference reaches 64.0, the product steps
// and the final shift are skipped. The first word of a row skips the exp and goes straight to
// the log; in exclusive mode it skips the log too and emits negative infinity.
// The finished result sits in an output register, so the next word may enter while it waits.
// A word that finishes while that register is still full holds in its emit step until the
// register is free.
`include "cumulative_log_sum_exp_scan_macros.svh"

module cumulative_log_sum_exp_scan #(
  parameter int VALUE_FRAC_BITS = clse_pkg::VALUE_FRAC_BITS,
  parameter int SUM_INT_BITS    = clse_pkg::SUM_INT_BITS,
  parameter int SUM_FRAC_BITS   = clse_pkg::SUM_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_value_i,
  input  logic        row_start_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        exclusive_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] scan_value_o,
  output logic        is_neg_infinity_o,
  output logic        sum_saturated_o
);

  localparam int SW  = SUM_INT_BITS + SUM_FRAC_BITS;
  localparam int SHW = $clog2(SW);
  localparam int JW  = $clog2(SHW);
  localparam logic [SW-1:0] SUM_ONE = SW'(1) << SUM_FRAC_BITS;
  localparam logic [SW-1:0] SUM_TOP = '1;
  localparam logic [32:0]   EXP_LIMIT = 33'(64) << VALUE_FRAC_BITS;
  localparam clse_pkg::pow_tab_t POW_TAB = clse_pkg::build_pow_tab();

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_UPD     = 4'd2;
  localparam logic [3:0] S_EXP_T   = 4'd3;
  localparam logic [3:0] S_EXP_P   = 4'd4;
  localparam logic [3:0] S_EXP_S   = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_MS_LO   = 4'd7;
  localparam logic [3:0] S_MS_HI   = 4'd8;
  localparam logic [3:0] S_LG_INIT = 4'd9;
  localparam logic [3:0] S_LG_NORM = 4'd10;
  localparam logic [3:0] S_LG_SQ   = 4'd11;
  localparam logic [3:0] S_LG_MUL  = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0]     state_q, state_d;
  logic           excl_q;
  logic           has_q, has_d;
  logic [31:0]    max_q, max_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [31:0]    smp_q, smp_d;
  logic           gt_q, gt_d;
  logic [32:0]    dlt_q, dlt_d;
  logic [32:0]    p_q, p_d;
  logic [31:0]    f_q, f_d;
  logic [6:0]     n_q, n_d;
  logic [5:0]     k_q, k_d;
  logic [SW-1:0]  e_q, e_d;
  logic [SW-1:0]  acc_q, acc_d;
  logic [SW-1:0]  norm_q, norm_d;
  logic [SHW-1:0] shc_q, shc_d;
  logic [JW-1:0]  j_q, j_d;
  logic [31:0]    m_q, m_d;
  logic [27:0]    frac_q, frac_d;
  logic [4:0]     i_q, i_d;
  logic [4:0]     l2i_q, l2i_d;
  logic [31:0]    res_scan_q, res_scan_d;
  logic           res_neg_q, res_neg_d;
  logic           res_sat_q, res_sat_d;
  logic           out_valid_q;
  logic [31:0]    out_scan_q;
  logic           out_neg_q;
  logic           out_sat_q;

  clse_pkg::mul_op_e  mul_op;
  clse_pkg::mul_opd_t mul_opd;
  logic [65:0]        prod;

  logic             in_acc;
  logic             out_free;
  logic [SW+1:0]    tot;
  logic [65:0]      hi_sh;
  logic [SHW:0]     amt;
  logic [SW-1:0]    nx;
  logic [SW+30:0]   wide;
  logic [31:0]      sq;
  logic [7:0]       sh;
  logic [65:0]      lnv;
  logic signed [33:0] rsum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    mul_opd.dlt    = dlt_q;
    mul_opd.p      = p_q;
    mul_opd.tab    = POW_TAB[k_q];
    mul_opd.sum_lo = 33'(sum_q[31:0]);
    mul_opd.sum_hi = 33'(sum_q >> 32);
    mul_opd.e      = 33'(e_q);
    mul_opd.m      = 33'(m_q);
    mul_opd.l2     = {l2i_q, frac_q};
    unique case (state_q)
      S_EXP_T:  mul_op = clse_pkg::MUL_LOG2E;
      S_MS_LO:  mul_op = clse_pkg::MUL_SUM_LO;
      S_MS_HI:  mul_op = clse_pkg::MUL_SUM_HI;
      S_LG_SQ:  mul_op = clse_pkg::MUL_SQUARE;
      S_LG_MUL: mul_op = clse_pkg::MUL_LN2;
      default:  mul_op = clse_pkg::MUL_POW;
    endcase
  end

  clse_mul u_mul (
    .op_i   (mul_op),
    .opd_i  (mul_opd),
    .prod_o (prod)
  );

  always_comb begin
    state_d    = state_q;
    has_d      = has_q;
    max_d      = max_q;
    sum_d      = sum_q;
    smp_d      = smp_q;
    gt_d       = gt_q;
    dlt_d      = dlt_q;
    p_d        = p_q;
    f_d        = f_q;
    n_d        = n_q;
    k_d        = k_q;
    e_d        = e_q;
    acc_d      = acc_q;
    norm_d     = norm_q;
    shc_d      = shc_q;
    j_d        = j_q;
    m_d        = m_q;
    frac_d     = frac_q;
    i_d        = i_q;
    l2i_d      = l2i_q;
    res_scan_d = res_scan_q;
    res_neg_d  = res_neg_q;
    res_sat_d  = res_sat_q;
    tot        = '0;
    hi_sh      = '0;
    amt        = (SHW+1)'(1) << j_q;
    nx         = norm_q;
    wide       = '0;
    sq         = prod[61:30];
    sh         = 8'(n_q) + 8'(32 - SUM_FRAC_BITS);
    lnv        = prod >> (56 - VALUE_FRAC_BITS);
    rsum       = $signed({{2{max_q[31]}}, max_q}) + $signed(lnv[33:0]);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          smp_d = sample_value_i;
          if (row_start_i) begin
            has_d = 1'b0;
            max_d = '0;
            sum_d = '0;
          end
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (excl_q && has_q) begin
          state_d = S_LG_INIT;
        end else begin
          if (excl_q) begin
            res_scan_d = 32'h8000_0000;
            res_neg_d  = 1'b1;
            res_sat_d  = 1'b0;
          end
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (!has_q) begin
          sum_d   = SUM_ONE;
          max_d   = smp_q;
          has_d   = 1'b1;
          state_d = excl_q ? S_EMIT : S_LG_INIT;
        end else if ($signed(smp_q) > $signed(max_q)) begin
          gt_d    = 1'b1;
          dlt_d   = {smp_q[31], smp_q} - {max_q[31], max_q};
          state_d = S_EXP_T;
        end else begin
          gt_d    = 1'b0;
          dlt_d   = {max_q[31], max_q} - {smp_q[31], smp_q};
          state_d = S_EXP_T;
        end
      end
      S_EXP_T: begin
        if (dlt_q >= EXP_LIMIT) begin
          e_d     = '0;
          state_d = gt_q ? S_MS_LO : S_ACC;
        end else begin
          f_d     = prod[VALUE_FRAC_BITS-2 +: 32];
          n_d     = 7'(prod >> (VALUE_FRAC_BITS + 30));
          p_d     = 33'd1 << 32;
          k_d     = 6'd1;
          state_d = S_EXP_P;
        end
      end
      S_EXP_P: begin
        if (f_q[31]) p_d = prod[64:32];
        f_d = f_q << 1;
        k_d = k_q + 6'd1;
        if (k_q == 6'd32) state_d = S_EXP_S;
      end
      S_EXP_S: begin
        e_d     = SW'(p_q >> sh);
        state_d = gt_q ? S_MS_LO : S_ACC;
      end
      S_ACC: begin
        tot     = (SW+2)'(sum_q) + (SW+2)'(e_q);
        sum_d   = (tot > (SW+2)'(SUM_TOP)) ? SUM_TOP : SW'(tot);
        state_d = excl_q ? S_EMIT : S_LG_INIT;
      end
      S_MS_LO: begin
        acc_d   = SW'(prod >> SUM_FRAC_BITS);
        state_d = S_MS_HI;
      end
      S_MS_HI: begin
        hi_sh   = prod << (32 - SUM_FRAC_BITS);
        tot     = (SW+2)'(acc_q) + (SW+2)'(hi_sh) + (SW+2)'(SUM_ONE);
        sum_d   = (tot > (SW+2)'(SUM_TOP)) ? SUM_TOP : SW'(tot);
        max_d   = smp_q;
        state_d = excl_q ? S_EMIT : S_LG_INIT;
      end
      S_LG_INIT: begin
        if (sum_q < SUM_ONE) begin
          l2i_d   = '0;
          frac_d  = '0;
          state_d = S_LG_MUL;
        end else begin
          norm_d  = sum_q;
          shc_d   = '0;
          j_d     = JW'(SHW - 1);
          state_d = S_LG_NORM;
        end
      end
      S_LG_NORM: begin
        if ((norm_q >> (SW - int'(amt))) == '0) begin
          nx    = norm_q << amt;
          shc_d = shc_q + SHW'(amt);
        end
        norm_d = nx;
        j_d    = j_q - JW'(1);
        if (j_q == '0) begin
          wide    = {nx, 31'd0};
          m_d     = 32'(wide[SW+30 -: 31]);
          l2i_d   = 5'(SUM_INT_BITS - 1) - 5'(shc_d);
          frac_d  = '0;
          i_d     = '0;
          state_d = S_LG_SQ;
        end
      end
      S_LG_SQ: begin
        frac_d = {frac_q[26:0], sq[31]};
        m_d    = sq[31] ? (sq >> 1) : sq;
        i_d    = i_q + 5'd1;
        if (i_q == 5'd27) state_d = S_LG_MUL;
      end
      S_LG_MUL: begin
        if (!rsum[33] && (rsum[32:31] != 2'b00)) begin
          res_scan_d = 32'h7FFF_FFFF;
        end else if (rsum[33] && (rsum[32:31] != 2'b11)) begin
          res_scan_d = 32'h8000_0000;
        end else begin
          res_scan_d = rsum[31:0];
        end
        res_neg_d = 1'b0;
        res_sat_d = (sum_q == SUM_TOP);
        state_d   = excl_q ? S_UPD : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      excl_q      <= 1'b0;
      has_q       <= 1'b0;
      max_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      has_q   <= has_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      if (cfg_valid_i && cfg_ready_o) excl_q <= exclusive_mode_i;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    gt_q       <= gt_d;
    dlt_q      <= dlt_d;
    p_q        <= p_d;
    f_q        <= f_d;
    n_q        <= n_d;
    k_q        <= k_d;
    e_q        <= e_d;
    acc_q      <= acc_d;
    norm_q     <= norm_d;
    shc_q      <= shc_d;
    j_q        <= j_d;
    m_q        <= m_d;
    frac_q     <= frac_d;
    i_q        <= i_d;
    l2i_q      <= l2i_d;
    res_scan_q <= res_scan_d;
    res_neg_q  <= res_neg_d;
    res_sat_q  <= res_sat_d;
    if (state_q == S_EMIT && out_free) begin
      out_scan_q <= res_scan_q;
      out_neg_q  <= res_neg_q;
      out_sat_q  <= res_sat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scan_value_o      = out_scan_q;
  assign is_neg_infinity_o = out_neg_q;
  assign sum_saturated_o   = out_sat_q;

  `CLSE_ASSERT(a_neg_inf_form, (out_valid_o && is_neg_infinity_o) |-> (scan_value_o == 32'h8000_0000 && !sum_saturated_o))
  `CLSE_ASSERT(a_empty_row_sum, !has_q |-> (sum_q == '0))
  `CLSE_ASSERT(a_row_sum_floor, (has_q && state_q == S_IDLE) |-> (sum_q >= SUM_ONE))
  `CLSE_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// ===== src/clse_mul.sv =====
module clse_mul (
  input  clse_pkg::mul_op_e  op_i,
  input  clse_pkg::mul_opd_t opd_i,
  output logic [65:0]        prod_o
);

  logic [32:0] a;
  logic [32:0] b;

  always_comb begin
    unique case (op_i)
      clse_pkg::MUL_LOG2E: begin
        a = opd_i.dlt;
        b = clse_pkg::LOG2E_Q30;
      end
      clse_pkg::MUL_POW: begin
        a = opd_i.p;
        b = opd_i.tab;
      end
      clse_pkg::MUL_SUM_LO: begin
        a = opd_i.sum_lo;
        b = opd_i.e;
      end
      clse_pkg::MUL_SUM_HI: begin
        a = opd_i.sum_hi;
        b = opd_i.e;
      end
      clse_pkg::MUL_SQUARE: begin
        a = opd_i.m;
        b = opd_i.m;
      end
      clse_pkg::MUL_LN2: begin
        a = opd_i.l2;
        b = clse_pkg::LN2_Q28;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign prod_o = 66'(a) * 66'(b);

endmodule
